/* rtl/joint_move_conflict_checker_unit_assert.svh */
// Assertion macros of the port-level checker file of the joint move conflict checker.
`ifndef JOINT_MOVE_CONFLICT_CHECKER_UNIT_ASSERT_SVH
`define JOINT_MOVE_CONFLICT_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JMCC_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("jmcc assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JMCC_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("jmcc assertion failed");

`endif

/* rtl/jmcc_pkg.sv */
// Shared types and constants of the joint move conflict checker.
package jmcc_pkg;

    localparam int MAX_AGENTS_DEF = 8;
    localparam int COORD_BITS_DEF = 10;
    localparam int STATUS_W       = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID    = 2'd0,
        ST_VERTEX   = 2'd1,
        ST_EDGE     = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_DRAIN,
        S_REPORT
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // store accepted agent or flag overflow
        logic init_pairs;  // pair indices to (0,1)
        logic issue;       // read current pair, step indices
        logic report;      // result shown this cycle, clear set
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic overflow;
        logic short_set;   // fewer than two agents stored
        logic pair_last;   // current pair is the final one
    } dp_sts_t;

endpackage

/* rtl/jmcc_datapath.sv */
// Agent store, pair index counters and conflict compare of the checker.
module jmcc_datapath #(
    parameter int MAX_AGENTS = jmcc_pkg::MAX_AGENTS_DEF,
    parameter int COORD_BITS = jmcc_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  jmcc_pkg::dp_cmd_t                  cmd,
    input  logic [COORD_BITS-1:0]              cur_x,
    input  logic [COORD_BITS-1:0]              cur_y,
    input  logic [COORD_BITS-1:0]              next_x,
    input  logic [COORD_BITS-1:0]              next_y,
    output jmcc_pkg::dp_sts_t                  sts,
    output logic [jmcc_pkg::STATUS_W-1:0]      status
);

    localparam int IDX_W   = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int CNT_W   = $clog2(MAX_AGENTS + 1);
    localparam int ENTRY_W = 4 * COORD_BITS;

    // entry layout: {cur_x, cur_y, next_x, next_y}
    logic [ENTRY_W-1:0] mem [MAX_AGENTS];

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [IDX_W-1:0]   a_reg, a_next;
    logic [IDX_W-1:0]   b_reg, b_next;
    logic               rd_valid_reg;
    logic [ENTRY_W-1:0] rd_a_reg, rd_b_reg;
    logic               vtx_reg, vtx_next;
    logic               edg_reg, edg_next;

    logic               full;
    logic [CNT_W-1:0]   cnt_m1, cnt_m2;
    logic               b_at_end;
    logic               vtx_hit, edg_hit;

    logic [COORD_BITS-1:0] a_cx, a_cy, a_nx, a_ny;
    logic [COORD_BITS-1:0] b_cx, b_cy, b_nx, b_ny;

    assign full     = (count_reg == CNT_W'(MAX_AGENTS));
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign cnt_m2   = count_reg - CNT_W'(2);
    assign b_at_end = (CNT_W'(b_reg) == cnt_m1);

    assign sts.overflow  = ovf_reg;
    assign sts.short_set = (count_reg < CNT_W'(2));
    assign sts.pair_last = b_at_end && (CNT_W'(a_reg) == cnt_m2);

    assign {a_cx, a_cy, a_nx, a_ny} = rd_a_reg;
    assign {b_cx, b_cy, b_nx, b_ny} = rd_b_reg;

    assign vtx_hit = (a_nx == b_nx) && (a_ny == b_ny);
    assign edg_hit = (a_nx == b_cx) && (a_ny == b_cy) && (b_nx == a_cx) && (b_ny == a_cy);

    // vertex outranks edge, overflow outranks both
    always_comb
    begin
        priority if (ovf_reg)
            status = jmcc_pkg::ST_OVERFLOW;
        else if (vtx_reg)
            status = jmcc_pkg::ST_VERTEX;
        else if (edg_reg)
            status = jmcc_pkg::ST_EDGE;
        else
            status = jmcc_pkg::ST_VALID;
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        vtx_next   = vtx_reg;
        edg_next   = edg_reg;

        if (cmd.load)
        begin
            if (full)
                ovf_next = 1'b1;
            else
                count_next = count_reg + CNT_W'(1);
        end

        if (cmd.init_pairs)
        begin
            a_next = '0;
            b_next = IDX_W'(1);
        end
        else if (cmd.issue)
        begin
            if (b_at_end)
            begin
                a_next = a_reg + IDX_W'(1);
                b_next = a_reg + IDX_W'(2);
            end
            else
                b_next = b_reg + IDX_W'(1);
        end

        if (rd_valid_reg)
        begin
            vtx_next = vtx_reg | vtx_hit;
            edg_next = edg_reg | edg_hit;
        end

        if (cmd.report)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
            vtx_next   = 1'b0;
            edg_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            a_reg        <= '0;
            b_reg        <= '0;
            rd_valid_reg <= 1'b0;
            vtx_reg      <= 1'b0;
            edg_reg      <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            rd_valid_reg <= cmd.issue;
            vtx_reg      <= vtx_next;
            edg_reg      <= edg_next;
        end
    end

    // agent store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
            mem[count_reg[IDX_W-1:0]] <= {cur_x, cur_y, next_x, next_y};
        if (cmd.issue)
        begin
            rd_a_reg <= mem[a_reg];
            rd_b_reg <= mem[b_reg];
        end
    end

endmodule

/* rtl/jmcc_ctrl.sv */
// Sequencing state machine of the joint move conflict checker.
module jmcc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_agent,
    input  jmcc_pkg::dp_sts_t sts,
    output jmcc_pkg::dp_cmd_t cmd,
    output logic              busy,
    output logic              done
);

    jmcc_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= jmcc_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;

        unique case (state_reg)
            jmcc_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
                if (start && last_agent)
                    state_next = jmcc_pkg::S_PREP;
            end
            jmcc_pkg::S_PREP:
            begin
                cmd.init_pairs = 1'b1;
                if (sts.overflow || sts.short_set)
                    state_next = jmcc_pkg::S_REPORT;
                else
                    state_next = jmcc_pkg::S_SCAN;
            end
            jmcc_pkg::S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.pair_last)
                    state_next = jmcc_pkg::S_DRAIN;
            end
            jmcc_pkg::S_DRAIN:
            begin
                state_next = jmcc_pkg::S_REPORT;
            end
            jmcc_pkg::S_REPORT:
            begin
                cmd.report = 1'b1;
                done       = 1'b1;
                state_next = jmcc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = jmcc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/joint_move_conflict_checker_unit.sv */
// Top level of the joint move conflict checker: controller plus datapath.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  agent in  | start & !busy        | cur_x, cur_y, next_x, next_y, last_agent
//  result    | done (1-cycle pulse) | status
//
// An agent transaction is taken whenever start is high and busy is low; busy stays low between agents.
// The transaction with last_agent set raises busy. With n stored agents and
// n >= 2 the set then takes n*(n-1)/2 pair compares, one pair compare per cycle
// through the two read ports of the agent store, after a setup state and
// followed by a read-latency state and the result state. A set of fewer than
// two agents, or one that overflowed, goes from setup straight to the result state.
// done is high in the last busy cycle; the receiver cannot stall it.
// rst_n is asynchronous, active low; it empties the set and idles the block.
module joint_move_conflict_checker_unit #(
    parameter int MAX_AGENTS = jmcc_pkg::MAX_AGENTS_DEF,
    parameter int COORD_BITS = jmcc_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [COORD_BITS-1:0]         cur_x,
    input  logic [COORD_BITS-1:0]         cur_y,
    input  logic [COORD_BITS-1:0]         next_x,
    input  logic [COORD_BITS-1:0]         next_y,
    input  logic                          last_agent,
    output logic                          done,
    output logic [jmcc_pkg::STATUS_W-1:0] status
);

    jmcc_pkg::dp_cmd_t cmd;
    jmcc_pkg::dp_sts_t sts;

    // sequencer: load agents, step through pairs, pulse the result
    jmcc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_agent (last_agent),
        .sts        (sts),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done)
    );

    // agent store and pair compare; status is held until the result cycle
    jmcc_datapath #(
        .MAX_AGENTS (MAX_AGENTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cur_x  (cur_x),
        .cur_y  (cur_y),
        .next_x (next_x),
        .next_y (next_y),
        .sts    (sts),
        .status (status)
    );

endmodule

/* rtl/jmcc_checker.sv */
// Port-level assertions for the joint move conflict checker, with bind.
`include "joint_move_conflict_checker_unit_assert.svh"

module jmcc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_agent,
    input logic done
);

    `JMCC_ASSERT_IMP(a_done_while_busy, done, busy)
    `JMCC_ASSERT_NXT(a_done_then_idle, done, !busy && !done)
    `JMCC_ASSERT_NXT(a_mid_agent_stays_ready, start && !busy && !last_agent, !busy)
    `JMCC_ASSERT_NXT(a_last_agent_goes_busy, start && !busy && last_agent, busy && !done)

endmodule

bind joint_move_conflict_checker_unit jmcc_checker u_jmcc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .last_agent (last_agent),
    .done       (done)
);

/* tb/joint_move_conflict_checker_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the joint move conflict checker: directed sets, random sets.
module joint_move_conflict_checker_unit_tb;

    localparam int NA          = jmcc_pkg::MAX_AGENTS_DEF;
    localparam int CW          = jmcc_pkg::COORD_BITS_DEF;
    localparam int COORD_MAX   = (1 << CW) - 1;
    // Longest legal quiet stretch: a full set's scan plus a long sender gap
    // at 86% idle. This limit leaves a wide margin.
    localparam int STALL_LIMIT = 2000;
    // Cycles allowed after the last status before the run ends.
    localparam int TAIL_CYCLES = 3 + NA * (NA - 1) / 2 + 10;

    // Predicts the status of each joint move from the agent transactions seen
    // and holds the statuses still owed by the block.
    class joint_move_predictor;
        logic [CW-1:0]          held_cur_x  [NA];
        logic [CW-1:0]          held_cur_y  [NA];
        logic [CW-1:0]          held_next_x [NA];
        logic [CW-1:0]          held_next_y [NA];
        int                     held_count;
        bit                     overflow_seen;
        jmcc_pkg::status_code_t pending_status [$];
        int                     error_count;

        function new();
            held_count    = 0;
            overflow_seen = 1'b0;
            error_count   = 0;
        endfunction

        // Vertex pass over all pairs first, so it wins over a swap.
        function jmcc_pkg::status_code_t judge_move();
            int a;
            int b;
            for (a = 0; a < held_count; a++)
                for (b = a + 1; b < held_count; b++)
                    if (held_next_x[a] == held_next_x[b] && held_next_y[a] == held_next_y[b])
                        return jmcc_pkg::ST_VERTEX;
            for (a = 0; a < held_count; a++)
                for (b = a + 1; b < held_count; b++)
                    if (held_next_x[a] == held_cur_x[b] && held_next_y[a] == held_cur_y[b] &&
                        held_next_x[b] == held_cur_x[a] && held_next_y[b] == held_cur_y[a])
                        return jmcc_pkg::ST_EDGE;
            return jmcc_pkg::ST_VALID;
        endfunction

        function void note_agent(logic [CW-1:0] cx, logic [CW-1:0] cy,
                                 logic [CW-1:0] nx, logic [CW-1:0] ny, logic last);
            jmcc_pkg::status_code_t verdict;
            if (held_count < NA)
            begin
                held_cur_x[held_count]  = cx;
                held_cur_y[held_count]  = cy;
                held_next_x[held_count] = nx;
                held_next_y[held_count] = ny;
                held_count++;
            end
            else
                overflow_seen = 1'b1;
            if (last)
            begin
                verdict        = overflow_seen ? jmcc_pkg::ST_OVERFLOW : judge_move();
                pending_status = {pending_status, verdict};
                held_count     = 0;
                overflow_seen  = 1'b0;
            end
        endfunction

        function void check_status(logic [jmcc_pkg::STATUS_W-1:0] got);
            jmcc_pkg::status_code_t want;
            if (pending_status.size() == 0)
            begin
                $display("%0t: status %0d with no joint move pending", $time, got);
                error_count++;
                return;
            end
            want = pending_status.pop_front();
            if (got !== want)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d", $time, want, got);
                error_count++;
            end
        endfunction
    endclass

    // All block inputs are known from time zero.
    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          start      = 1'b0;
    logic [CW-1:0]                 cur_x      = '0;
    logic [CW-1:0]                 cur_y      = '0;
    logic [CW-1:0]                 next_x     = '0;
    logic [CW-1:0]                 next_y     = '0;
    logic                          last_agent = 1'b0;
    logic                          busy;
    logic                          done;
    logic [jmcc_pkg::STATUS_W-1:0] status;

    joint_move_predictor predictor;
    int                  idle_pct   = 0;   // chance in 100 that the sender skips a cycle
    int                  agents_sent = 0;

    joint_move_conflict_checker_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cur_x      (cur_x),
        .cur_y      (cur_y),
        .next_x     (next_x),
        .next_y     (next_y),
        .last_agent (last_agent),
        .done       (done),
        .status     (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // One agent transaction. Inputs move on the falling edge; the handshake is
    // judged on the rising edge with the pre-edge value of busy. When no idle
    // cycle is drawn, start simply stays high into the next transaction.
    task automatic drive_agent(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                               input logic [CW-1:0] nx, input logic [CW-1:0] ny,
                               input logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        start      <= 1'b1;
        cur_x      <= cx;
        cur_y      <= cy;
        next_x     <= nx;
        next_y     <= ny;
        last_agent <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predictor.note_agent(cx, cy, nx, ny, last);
        agents_sent++;
    endtask

    // One random joint move. Most sets fit the store; about one in ten
    // overflows it. Narrow windows and planted collisions make vertex and
    // swap conflicts frequent; wide draws exercise every coordinate bit.
    task automatic send_random_move();
        logic [CW-1:0] cx [NA + 3];
        logic [CW-1:0] cy [NA + 3];
        logic [CW-1:0] nx [NA + 3];
        logic [CW-1:0] ny [NA + 3];
        int n;
        int flavor;
        int span;
        int base_x;
        int base_y;
        int i;
        int j;
        int k;
        n      = ($urandom_range(0, 9) == 0) ? $urandom_range(NA + 1, NA + 3)
                                             : $urandom_range(1, NA);
        flavor = $urandom_range(0, 3);
        span   = (flavor == 1) ? 3 : (flavor == 2) ? 15 : COORD_MAX;
        base_x = $urandom_range(0, COORD_MAX - span);
        base_y = $urandom_range(0, COORD_MAX - span);
        for (i = 0; i < n; i++)
        begin
            cx[i] = CW'(base_x + $urandom_range(0, span));
            cy[i] = CW'(base_y + $urandom_range(0, span));
            nx[i] = CW'(base_x + $urandom_range(0, span));
            ny[i] = CW'(base_y + $urandom_range(0, span));
        end
        // planted conflict between two agents inside the stored range
        if (flavor == 3 && n >= 2)
        begin
            k = (n > NA) ? NA : n;
            i = $urandom_range(0, k - 2);
            j = $urandom_range(i + 1, k - 1);
            if ($urandom_range(0, 1))
            begin
                nx[j] = nx[i];
                ny[j] = ny[i];
            end
            else
            begin
                cx[j] = nx[i];
                cy[j] = ny[i];
                nx[j] = cx[i];
                ny[j] = cy[i];
            end
        end
        for (i = 0; i < n; i++)
            drive_agent(cx[i], cy[i], nx[i], ny[i], i == n - 1);
    endtask

    // Every status the block shows is checked on the edge that ends its cycle.
    always @(posedge clk)
        if (rst_n && done)
            predictor.check_status(status);

    // Watchdog: ends the run when no transaction and no status appear for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        predictor = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed sets, no idling.
        // single agent at the low corner, then at the high corner: valid
        drive_agent('0, '0, '0, '0, 1'b1);
        drive_agent(CW'(COORD_MAX), CW'(COORD_MAX), CW'(COORD_MAX), CW'(COORD_MAX), 1'b1);
        // two agents aiming at the same far corner: vertex
        drive_agent('0, '0, CW'(COORD_MAX), CW'(COORD_MAX), 1'b0);
        drive_agent(CW'(COORD_MAX), '0, CW'(COORD_MAX), CW'(COORD_MAX), 1'b1);
        // two agents trading opposite corners: edge swap
        drive_agent('0, '0, CW'(COORD_MAX), CW'(COORD_MAX), 1'b0);
        drive_agent(CW'(COORD_MAX), CW'(COORD_MAX), '0, '0, 1'b1);
        // swap plus shared target in one set: vertex wins
        drive_agent(CW'(1), CW'(1), CW'(2), CW'(2), 1'b0);
        drive_agent(CW'(2), CW'(2), CW'(1), CW'(1), 1'b0);
        drive_agent(CW'(5), CW'(5), CW'(2), CW'(2), 1'b1);
        // three agents, distinct targets, no swap: valid
        drive_agent(CW'(10), CW'(20), CW'(11), CW'(20), 1'b0);
        drive_agent(CW'(11), CW'(20), CW'(12), CW'(20), 1'b0);
        drive_agent(CW'(12), CW'(20), CW'(12), CW'(21), 1'b1);
        // one agent past a full store: overflow, regardless of contents
        for (int a = 0; a <= NA; a++)
            drive_agent(CW'(a), CW'(a), CW'(a + 1), CW'(a), a == NA);

        // Random sets across sender idle phases.
        idle_pct = 0;
        while (agents_sent < 450)
            send_random_move();
        idle_pct = 86;
        while (agents_sent < 850)
            send_random_move();
        idle_pct = 16;
        while (agents_sent < 1270)
            send_random_move();

        @(negedge clk);
        start <= 1'b0;
        while (predictor.pending_status.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (predictor.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
